/* hdl/fld_pkg.sv */
// Shared types and constants for the fixed-length frame deframer.
package fld_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_HEADER_BYTE  = 2'd0;
    localparam logic [1:0] REG_FOOTER_BYTE  = 2'd1;
    localparam logic [1:0] REG_FRAME_LENGTH = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] HEADER_RESET = 8'h78;
    localparam logic [7:0] FOOTER_RESET = 8'h76;
    localparam logic [6:0] LENGTH_RESET = 7'd14;

    // Shortest frame; shorter settings act as this length
    localparam logic [6:0] MIN_FRAME_LEN = 7'd14;

    // Frame offsets of the captured fields
    localparam logic [6:0] OFF_PITCH_FIRST = 7'd1;
    localparam logic [6:0] OFF_PITCH_LAST  = 7'd4;
    localparam logic [6:0] OFF_YAW_FIRST   = 7'd5;
    localparam logic [6:0] OFF_YAW_LAST    = 7'd8;
    localparam logic [6:0] OFF_SPEED_FIRST = 7'd9;
    localparam logic [6:0] OFF_SPEED_LAST  = 7'd10;
    localparam logic [6:0] OFF_COLOR       = 7'd11;
    localparam logic [6:0] OFF_BUFF        = 7'd12;

    // Frame status codes
    localparam logic STATUS_GOOD       = 1'b0;
    localparam logic STATUS_FOOTER_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] footer_byte;
        logic [6:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic        frame_status;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_bits;
        logic [15:0] projectile_speed;
        logic [7:0]  color_code;
        logic [7:0]  buff_code;
    } result_t;

endpackage

/* hdl/fld_in_reg.sv */
// Input register stage holding one received byte.
module fld_in_reg
    import fld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       byte_valid_o,
    output logic [7:0] byte_o,
    input  logic       byte_take_i
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    assign s_ready      = !valid_reg || byte_take_i;
    assign byte_valid_o = valid_reg;
    assign byte_o       = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (byte_take_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

/* hdl/fld_capture.sv */
// Frame byte counter and field capture registers.
module fld_capture
    import fld_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg_i,
    input  logic       step_i,
    input  logic [7:0] byte_i,
    output logic       res_fire_o,
    output result_t    res_o
);

    logic [6:0]  byte_count_reg, byte_count_next;
    logic [31:0] pitch_reg;
    logic [31:0] yaw_reg;
    logic [15:0] speed_reg;
    logic [7:0]  color_reg;
    logic [7:0]  buff_reg;
    logic [6:0]  last_off;
    logic        hunting;
    logic        frame_end;

    assign last_off  = (cfg_i.frame_length < MIN_FRAME_LEN) ? (MIN_FRAME_LEN - 7'd1)
                                                            : (cfg_i.frame_length - 7'd1);
    assign hunting   = (byte_count_reg == 7'd0);
    assign frame_end = !hunting && (byte_count_reg >= last_off);
    assign res_fire_o = step_i && frame_end;

    always_comb begin
        byte_count_next = byte_count_reg;
        if (step_i) begin
            if (hunting) begin
                if (byte_i == cfg_i.header_byte) begin
                    byte_count_next = 7'd1;
                end
            end else if (frame_end) begin
                byte_count_next = 7'd0;
            end else begin
                byte_count_next = byte_count_reg + 7'd1;
            end
        end
    end

    // Last byte offset is at least 13, so captures are complete on it.
    always_comb begin
        res_o = '0;
        if (byte_i == cfg_i.footer_byte) begin
            res_o.frame_status     = STATUS_GOOD;
            res_o.pitch_bits       = pitch_reg;
            res_o.yaw_bits         = yaw_reg;
            res_o.projectile_speed = speed_reg;
            res_o.color_code       = color_reg;
            res_o.buff_code        = buff_reg;
        end else begin
            res_o.frame_status = STATUS_FOOTER_ERR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 7'd0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    // Little-endian shift-in of multi-byte fields
    always_ff @(posedge aclk) begin
        if (step_i && !hunting) begin
            if (byte_count_reg >= OFF_PITCH_FIRST && byte_count_reg <= OFF_PITCH_LAST) begin
                pitch_reg <= {byte_i, pitch_reg[31:8]};
            end
            if (byte_count_reg >= OFF_YAW_FIRST && byte_count_reg <= OFF_YAW_LAST) begin
                yaw_reg <= {byte_i, yaw_reg[31:8]};
            end
            if (byte_count_reg >= OFF_SPEED_FIRST && byte_count_reg <= OFF_SPEED_LAST) begin
                speed_reg <= {byte_i, speed_reg[15:8]};
            end
            if (byte_count_reg == OFF_COLOR) begin
                color_reg <= byte_i;
            end
            if (byte_count_reg == OFF_BUFF) begin
                buff_reg <= byte_i;
            end
        end
    end

    a_end_returns_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire_o |=> (byte_count_reg == 7'd0))
        else $error("frame end did not return to hunting");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg != 7'h7F)
        else $error("byte count ran past longest frame");

    a_hunt_drops_non_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_i && hunting && (byte_i != cfg_i.header_byte)) |=> (byte_count_reg == 7'd0))
        else $error("non-header byte started a frame");

    a_no_result_while_hunting: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire_o |-> (byte_count_reg >= (MIN_FRAME_LEN - 7'd1)))
        else $error("result before minimum frame length");

endmodule

/* hdl/fld_out_reg.sv */
// Result register with valid/ready handshake.
module fld_out_reg
    import fld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_i,
    input  result_t            res_i,
    output logic               ready_o,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_status,
    output logic [31:0]        m_pitch_bits,
    output logic [31:0]        m_yaw_bits,
    output logic signed [15:0] m_projectile_speed,
    output logic [7:0]         m_color_code,
    output logic [7:0]         m_buff_code
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign ready_o = !valid_reg || m_ready;
    assign m_valid = valid_reg;

    assign m_frame_status     = res_reg.frame_status;
    assign m_pitch_bits       = res_reg.pitch_bits;
    assign m_yaw_bits         = res_reg.yaw_bits;
    assign m_projectile_speed = $signed(res_reg.projectile_speed);
    assign m_color_code       = res_reg.color_code;
    assign m_buff_code        = res_reg.buff_code;

    always_comb begin
        valid_next = valid_reg;
        if (load_i) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> ready_o)
        else $error("result loaded over a pending transfer");

    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_frame_status == STATUS_FOOTER_ERR)) |->
        (m_pitch_bits == 32'd0 && m_yaw_bits == 32'd0 && m_projectile_speed == 16'sd0
         && m_color_code == 8'd0 && m_buff_code == 8'd0))
        else $error("footer error carried field data");

endmodule

/* hdl/fixed_length_frame_deframer.sv */
// Top level of the fixed-length frame deframer.
//
// Usage:
//  - s_ channel: one received serial byte per transfer (s_rx_byte).
//  - m_ channel: one result per completed frame: status, pitch and yaw raw
//    float bits, signed speed, color and buff bytes.
//  - cfg_ port: write-only; cfg_we with cfg_index (0 header, 1 footer,
//    2 frame length) and cfg_wdata. Write only while no bytes are in flight.
//  - While hunting, bytes other than the header are dropped. After the
//    header, bytes are counted to the frame length; the last byte is
//    checked against the footer. A mismatch gives status 1 with zero fields.
//  - Result path: a frame's last byte passes the input register, then the
//    result register, before its result is on m_.
//  - Throughput: one byte per cycle unless a result is held with m_ready low,
//    set by the single capture stage between input and result registers.
//  - Reset: synchronous aresetn clears both valid flags, puts the counter
//    into hunting and loads the default header, footer and length.
//  - Stall: when m_ready is low the result holds; the input register still
//    takes one more byte, then s_ready drops until the result moves.
module fixed_length_frame_deframer
    import fld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_status,
    output logic [31:0]        m_pitch_bits,
    output logic [31:0]        m_yaw_bits,
    output logic signed [15:0] m_projectile_speed,
    output logic [7:0]         m_color_code,
    output logic [7:0]         m_buff_code,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata
);

    cfg_t       cfg_reg, cfg_next;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_ready;
    logic       step;
    logic       res_fire;
    result_t    res;

    // Configuration registers; writes beyond the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_HEADER_BYTE:  cfg_next.header_byte  = cfg_wdata;
                REG_FOOTER_BYTE:  cfg_next.footer_byte  = cfg_wdata;
                REG_FRAME_LENGTH: cfg_next.frame_length = cfg_wdata[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_byte  <= HEADER_RESET;
            cfg_reg.footer_byte  <= FOOTER_RESET;
            cfg_reg.frame_length <= LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // A buffered byte moves through the capture stage when the result
    // register can take whatever it may produce.
    assign step = byte_valid && out_ready;

    fld_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .byte_valid_o (byte_valid),
        .byte_o       (byte_data),
        .byte_take_i  (step)
    );

    fld_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_i      (cfg_reg),
        .step_i     (step),
        .byte_i     (byte_data),
        .res_fire_o (res_fire),
        .res_o      (res)
    );

    fld_out_reg u_out_reg (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .load_i             (res_fire),
        .res_i              (res),
        .ready_o            (out_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_status     (m_frame_status),
        .m_pitch_bits       (m_pitch_bits),
        .m_yaw_bits         (m_yaw_bits),
        .m_projectile_speed (m_projectile_speed),
        .m_color_code       (m_color_code),
        .m_buff_code        (m_buff_code)
    );

endmodule

/* dv/fld_result_checker.sv */
// Checker for the frame deframer: tracks framing state, predicts results and compares them.
`timescale 1ns / 100ps

module fld_result_checker
    import fld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_frame_status,
    input  logic [31:0] m_pitch_bits,
    input  logic [31:0] m_yaw_bits,
    input  logic [15:0] m_projectile_speed,
    input  logic [7:0]  m_color_code,
    input  logic [7:0]  m_buff_code,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    output int          pending_frames,
    output int          fail_count
);

    // shadow registers
    logic [7:0]  hdr_val;
    logic [7:0]  ftr_val;
    logic [6:0]  len_val;

    // framing state
    logic [6:0]  rx_offset;
    logic [31:0] pitch_acc;
    logic [31:0] yaw_acc;
    logic [15:0] speed_acc;
    logic [7:0]  color_acc;
    logic [7:0]  buff_acc;

    result_t expected_frames [$];

    // Advances the framing state by one byte; returns 1 when the byte closes a frame.
    function automatic bit take_rx_byte(input logic [7:0] b, output result_t r);
        logic [6:0] last_off;
        r = '0;
        last_off = ((len_val < MIN_FRAME_LEN) ? MIN_FRAME_LEN : len_val) - 7'd1;
        if (rx_offset == 7'd0) begin
            if (b == hdr_val) rx_offset = 7'd1;
            return 1'b0;
        end
        if (rx_offset >= OFF_PITCH_FIRST && rx_offset <= OFF_PITCH_LAST) begin
            pitch_acc = {b, pitch_acc[31:8]};
        end else if (rx_offset >= OFF_YAW_FIRST && rx_offset <= OFF_YAW_LAST) begin
            yaw_acc = {b, yaw_acc[31:8]};
        end else if (rx_offset >= OFF_SPEED_FIRST && rx_offset <= OFF_SPEED_LAST) begin
            speed_acc = {b, speed_acc[15:8]};
        end else if (rx_offset == OFF_COLOR) begin
            color_acc = b;
        end else if (rx_offset == OFF_BUFF) begin
            buff_acc = b;
        end
        // offset at or past the end also covers a length lowered mid-frame
        if (rx_offset >= last_off) begin
            rx_offset = 7'd0;
            if (b == ftr_val) begin
                r.frame_status     = STATUS_GOOD;
                r.pitch_bits       = pitch_acc;
                r.yaw_bits         = yaw_acc;
                r.projectile_speed = speed_acc;
                r.color_code       = color_acc;
                r.buff_code        = buff_acc;
            end else begin
                r.frame_status = STATUS_FOOTER_ERR;
            end
            return 1'b1;
        end
        rx_offset = rx_offset + 7'd1;
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            hdr_val   = HEADER_RESET;
            ftr_val   = FOOTER_RESET;
            len_val   = LENGTH_RESET;
            rx_offset = 7'd0;
            pitch_acc = '0;
            yaw_acc   = '0;
            speed_acc = '0;
            color_acc = '0;
            buff_acc  = '0;
            expected_frames.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (take_rx_byte(s_rx_byte, want)) expected_frames = {expected_frames, want};
            end
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no frame outstanding");
                    fail_count++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_status", 32'(want.frame_status), 32'(m_frame_status));
                    check_field("pitch_bits", want.pitch_bits, m_pitch_bits);
                    check_field("yaw_bits", want.yaw_bits, m_yaw_bits);
                    check_field("projectile_speed", 32'(want.projectile_speed),
                                32'(m_projectile_speed));
                    check_field("color_code", 32'(want.color_code), 32'(m_color_code));
                    check_field("buff_code", 32'(want.buff_code), 32'(m_buff_code));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_HEADER_BYTE: begin
                        hdr_val = cfg_wdata;
                    end
                    REG_FOOTER_BYTE: begin
                        ftr_val = cfg_wdata;
                    end
                    REG_FRAME_LENGTH: begin
                        len_val = cfg_wdata[6:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_frames <= expected_frames.size();
    end

endmodule

/* dv/tb_fixed_length_frame_deframer.sv */
// Testbench top for the frame deframer: byte stimulus, register writes and verdict.
`timescale 1ns / 100ps

module tb_fixed_length_frame_deframer
    import fld_pkg::*;
();

    // Generous bound on the run length for a few thousand bytes.
    localparam int CYCLE_LIMIT     = 400000;
    // Frame bytes per random phase; bytes dropped while hunting are not counted.
    localparam int BYTES_PER_PHASE = 600;
    // Margin past the input and result registers before touching the registers.
    localparam int LATENCY_PAD     = 4;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_frame_status;
    logic [31:0]        m_pitch_bits;
    logic [31:0]        m_yaw_bits;
    logic signed [15:0] m_projectile_speed;
    logic [7:0]         m_color_code;
    logic [7:0]         m_buff_code;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = REG_HEADER_BYTE;
    logic [7:0]         cfg_wdata = 8'h00;

    int pending_frames;
    int fail_count;
    int cycle_count      = 0;
    int send_idle_pct    = 10;
    int recv_idle_pct    = 48;
    int frame_bytes_sent = 0;

    // Framing as the stimulus sees it; cur_len is the effective length.
    logic [7:0] cur_hdr = HEADER_RESET;
    logic [7:0] cur_ftr = FOOTER_RESET;
    int         cur_len = 14;

    always #4 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fixed_length_frame_deframer: mismatch");
            $finish;
        end
    end

    // Receiver backpressure, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    fixed_length_frame_deframer uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_status     (m_frame_status),
        .m_pitch_bits       (m_pitch_bits),
        .m_yaw_bits         (m_yaw_bits),
        .m_projectile_speed (m_projectile_speed),
        .m_color_code       (m_color_code),
        .m_buff_code        (m_buff_code),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    fld_result_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_status     (m_frame_status),
        .m_pitch_bits       (m_pitch_bits),
        .m_yaw_bits         (m_yaw_bits),
        .m_projectile_speed (m_projectile_speed),
        .m_color_code       (m_color_code),
        .m_buff_code        (m_buff_code),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .pending_frames     (pending_frames),
        .fail_count         (fail_count)
    );

    // One byte transfer, optionally preceded by idle time with valid low.
    // Valid stays high after the transfer so back-to-back bytes need no dip.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Frame payload: mostly random, with extremes and the header/footer
    // values showing up as plain data now and then.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return cur_hdr;
            3:       return cur_ftr;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Header, n_data payload bytes, then the footer or a corrupted footer.
    task automatic push_frame(input int n_data, input bit good_footer);
        push_byte(cur_hdr);
        for (int i = 0; i < n_data; i++) push_byte(payload_byte());
        push_byte(good_footer ? cur_ftr : cur_ftr ^ 8'($urandom_range(255, 1)));
        frame_bytes_sent += n_data + 2;
    endtask

    // Mostly well-formed frames; the rest carry a bad footer, leading noise
    // while hunting, or a payload count that misses the frame length.
    task automatic random_frame();
        int kind;
        int n_data;
        kind   = $urandom_range(99);
        n_data = cur_len - 2;
        if (kind >= 80 && kind < 90) begin
            repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
        end
        if (kind >= 90) n_data = n_data - 3 + $urandom_range(6);
        push_frame(n_data, !(kind >= 70 && kind < 80));
        // occasional hold-off until the result side has caught up
        if ($urandom_range(99) < 3) wait_for_results();
    endtask

    // Sender goes quiet until every predicted frame has come out, then lets
    // the pipeline settle so a partial frame's bytes are absorbed too.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_frames != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes all three registers; only the low 7 bits of len_word count.
    task automatic set_framing(input logic [7:0] hdr, input logic [7:0] ftr,
                               input logic [7:0] len_word);
        write_reg(REG_HEADER_BYTE, hdr);
        write_reg(REG_FOOTER_BYTE, ftr);
        write_reg(REG_FRAME_LENGTH, len_word);
        cur_hdr = hdr;
        cur_ftr = ftr;
        cur_len = int'((len_word[6:0] < MIN_FRAME_LEN) ? MIN_FRAME_LEN : len_word[6:0]);
    endtask

    initial begin
        logic [7:0] sample_bytes [12];
        sample_bytes = '{8'h00, 8'hFF, 8'h78, 8'h01, 8'h80, 8'h7F,
                         8'hA5, 8'h5A, 8'h00, 8'h80, 8'hFF, 8'h78};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset framing: a stray byte dropped while hunting, then a good
        // frame whose payload holds byte extremes and the header value.
        push_byte(8'h77);
        push_byte(cur_hdr);
        foreach (sample_bytes[i]) push_byte(sample_bytes[i]);
        push_byte(cur_ftr);
        // Footer error: status set, captured fields zeroed.
        push_frame(cur_len - 2, 1'b0);
        wait_for_results();

        // Length lowered mid-frame: stop at offset 14 of a 64-byte frame,
        // then drop the length to 0 (acts as 14); the next byte closes it.
        set_framing(cur_hdr, cur_ftr, 8'd64);
        push_byte(cur_hdr);
        repeat (14) push_byte(payload_byte());
        wait_for_results();
        set_framing(cur_hdr, cur_ftr, 8'd0);
        push_byte(cur_ftr);
        // Short length setting on a whole frame.
        push_frame(cur_len - 2, 1'b1);
        wait_for_results();

        // Longest frames the 7-bit length allows, then 64 with bit 7 set in
        // the written word.
        set_framing(cur_hdr, cur_ftr, 8'h7F);
        push_frame(cur_len - 2, 1'b1);
        push_frame(cur_len - 2, 1'b0);
        wait_for_results();
        set_framing(cur_hdr, cur_ftr, 8'hC0);
        push_frame(cur_len - 2, 1'b1);
        push_frame(cur_len - 2, 1'b1);

        // Random phases: sender-light/receiver-heavy idling, then the
        // reverse, then no idling at all. Registers change only once the
        // result side is drained.
        for (int phase = 0; phase < 3; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 48;
                    set_framing(8'h00, 8'hFF, 8'd14);
                end
                1: begin
                    send_idle_pct = 48;
                    recv_idle_pct = 10;
                    set_framing(8'hFF, 8'h00,
                                {1'($urandom_range(1)), 7'($urandom_range(22, 14))});
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    set_framing(8'($urandom_range(255)), 8'($urandom_range(255)),
                                {1'($urandom_range(1)), 7'($urandom_range(30, 10))});
                end
            endcase
            frame_bytes_sent = 0;
            while (frame_bytes_sent < BYTES_PER_PHASE) random_frame();
        end

        wait_for_results();
        repeat (2 * LATENCY_PAD) @(posedge aclk);
        if (fail_count == 0) begin
            $display("fixed_length_frame_deframer: match");
        end else begin
            $display("fixed_length_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule
